/* rtl/stis_pkg.sv */
package stis_pkg;

  localparam int IDX_W         = 10;
  localparam int PORT_VAL_W    = 32;
  localparam int IDX_LIMIT     = 1 << IDX_W;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_MID,
    ST_DONE
  } stis_state_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } tbl_cmd_t;

  // entries reachable through a 10-bit index
  function automatic int idx_depth(input int depth);
    return (depth > IDX_LIMIT) ? IDX_LIMIT : depth;
  endfunction

  function automatic int addr_width(input int depth);
    return (idx_depth(depth) > 2) ? $clog2(idx_depth(depth)) : 1;
  endfunction

  // stored value width, keys and values keep at most the port width
  function automatic int store_width(input int vw);
    return (vw < PORT_VAL_W) ? vw : PORT_VAL_W;
  endfunction

endpackage

/* rtl/stis_table.sv */
module stis_table #(
  parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = stis_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                          clk,
  input  stis_pkg::tbl_cmd_t                            cmd,
  input  logic [stis_pkg::addr_width(TABLE_DEPTH)-1:0]  addr,
  input  logic [stis_pkg::store_width(VALUE_WIDTH)-1:0] wdata,
  output logic [stis_pkg::store_width(VALUE_WIDTH)-1:0] rdata
);
  import stis_pkg::*;

  localparam int Depth  = idx_depth(TABLE_DEPTH);
  localparam int StoreW = store_width(VALUE_WIDTH);

  logic [StoreW-1:0] mem [Depth];
  logic [StoreW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/stis_ctrl.sv */
module stis_ctrl #(
  parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = stis_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  logic                                          in_action,
  input  logic [stis_pkg::IDX_W-1:0]                    in_entry_index,
  input  logic signed [stis_pkg::PORT_VAL_W-1:0]        in_entry_value,
  input  logic signed [stis_pkg::PORT_VAL_W-1:0]        in_search_key,
  input  logic [stis_pkg::IDX_W-1:0]                    in_lower_index,
  input  logic [stis_pkg::IDX_W-1:0]                    in_upper_index,
  input  logic                                          in_clamp_above,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [stis_pkg::IDX_W-1:0]                    out_interval_index,
  output logic                                          out_found,
  output stis_pkg::tbl_cmd_t                            mem_cmd,
  output logic [stis_pkg::addr_width(TABLE_DEPTH)-1:0]  mem_addr,
  output logic [stis_pkg::store_width(VALUE_WIDTH)-1:0] mem_wdata,
  input  logic [stis_pkg::store_width(VALUE_WIDTH)-1:0] mem_rdata
);
  import stis_pkg::*;

  localparam int Depth  = idx_depth(TABLE_DEPTH);
  localparam int AddrW  = addr_width(TABLE_DEPTH);
  localparam int StoreW = store_width(VALUE_WIDTH);

  stis_state_t state_r, state_nxt;

  logic signed [StoreW-1:0] key_r, key_nxt;
  logic [AddrW-1:0]         i1_r, i1_nxt;
  logic [AddrW-1:0]         i3_r, i3_nxt;
  logic [AddrW-1:0]         mid_r, mid_nxt;
  logic                     clamp_r, clamp_nxt;
  logic [AddrW-1:0]         res_idx_r, res_idx_nxt;
  logic                     res_found_r, res_found_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]         out_idx_r, out_idx_nxt;
  logic                     out_found_r, out_found_nxt;

  logic                     accept;
  logic                     entry_ok;
  logic                     query_bad;
  logic signed [StoreW-1:0] tbl_val;
  logic                     key_lt;
  logic                     key_gt;
  logic [AddrW-1:0]         span_cur;
  logic [AddrW:0]           sum_cur;
  logic [AddrW-1:0]         mid_cur;
  logic [AddrW-1:0]         i1_step;
  logic [AddrW-1:0]         i3_step;
  logic [AddrW-1:0]         span_step;
  logic [AddrW:0]           sum_step;
  logic [AddrW-1:0]         mid_step;
  logic                     out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign entry_ok  = {1'b0, in_entry_index} < (IDX_W + 1)'(Depth);
  assign query_bad = !({1'b0, in_lower_index} < (IDX_W + 1)'(Depth))
                  || !({1'b0, in_upper_index} < (IDX_W + 1)'(Depth))
                  || (in_upper_index <= in_lower_index);

  assign tbl_val = $signed(mem_rdata);
  assign key_lt  = key_r < tbl_val;
  assign key_gt  = key_r > tbl_val;

  assign span_cur = i3_r - i1_r;
  assign sum_cur  = {1'b0, i1_r} + {1'b0, i3_r};
  assign mid_cur  = sum_cur[AddrW:1];

  // one bisection step on the entry just read at mid_r
  assign i1_step   = key_gt ? mid_r : i1_r;
  assign i3_step   = key_gt ? i3_r : mid_r;
  assign span_step = i3_step - i1_step;
  assign sum_step  = {1'b0, i1_step} + {1'b0, i3_step};
  assign mid_step  = sum_step[AddrW:1];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_action == ACT_QUERY)) begin
          state_nxt = query_bad ? ST_DONE : ST_LO;
        end
      end
      ST_LO: begin
        state_nxt = key_lt ? ST_DONE : ST_HI;
      end
      ST_HI: begin
        if (key_gt || (span_cur <= AddrW'(1))) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MID;
        end
      end
      ST_MID: begin
        if (span_step <= AddrW'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_cmd       = '0;
    mem_addr      = i1_r;
    mem_wdata     = in_entry_value[StoreW-1:0];
    key_nxt       = key_r;
    i1_nxt        = i1_r;
    i3_nxt        = i3_r;
    mid_nxt       = mid_r;
    clamp_nxt     = clamp_r;
    res_idx_nxt   = res_idx_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_idx_nxt   = out_idx_r;
    out_found_nxt = out_found_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_LOAD) begin
            mem_cmd.wr = entry_ok;
            mem_addr   = in_entry_index[AddrW-1:0];
          end else begin
            key_nxt       = $signed(in_search_key[StoreW-1:0]);
            i1_nxt        = in_lower_index[AddrW-1:0];
            i3_nxt        = in_upper_index[AddrW-1:0];
            clamp_nxt     = in_clamp_above;
            res_idx_nxt   = '0;
            res_found_nxt = 1'b0;
            if (!query_bad) begin
              mem_cmd.rd = 1'b1;
              mem_addr   = in_lower_index[AddrW-1:0];
            end
          end
        end
      end
      ST_LO: begin
        if (!key_lt) begin
          mem_cmd.rd = 1'b1;
          mem_addr   = i3_r;
        end
      end
      ST_HI: begin
        if (key_gt) begin
          res_idx_nxt   = clamp_r ? i3_r : '0;
          res_found_nxt = clamp_r;
        end else if (span_cur <= AddrW'(1)) begin
          res_idx_nxt   = i1_r;
          res_found_nxt = 1'b1;
        end else begin
          mem_cmd.rd = 1'b1;
          mem_addr   = mid_cur;
          mid_nxt    = mid_cur;
        end
      end
      ST_MID: begin
        i1_nxt = i1_step;
        i3_nxt = i3_step;
        if (span_step <= AddrW'(1)) begin
          res_idx_nxt   = i1_step;
          res_found_nxt = 1'b1;
        end else begin
          mem_cmd.rd = 1'b1;
          mem_addr   = mid_step;
          mid_nxt    = mid_step;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = IDX_W'(res_idx_r);
          out_found_nxt = res_found_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r       <= key_nxt;
    i1_r        <= i1_nxt;
    i3_r        <= i3_nxt;
    mid_r       <= mid_nxt;
    clamp_r     <= clamp_nxt;
    res_idx_r   <= res_idx_nxt;
    res_found_r <= res_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_interval_index = out_idx_r;
  assign out_found          = out_found_r;

endmodule

/* rtl/sorted_table_interval_search.sv */
// Sorted table interval search.
// Input channel (in_valid/in_ready): a beat with in_action = 0 writes
// in_entry_value into the table at in_entry_index; it yields no result and
// leaves in_ready high, so loads are taken back to back. A beat with
// in_action = 1 is a query and yields exactly one result beat on the output
// channel (out_valid/out_ready) with out_interval_index and out_found.
// A query with rejected limits goes from ST_IDLE straight to ST_DONE; else
// the key is compared with the lower entry in ST_LO, with the upper entry
// in ST_HI unless it lies below the lower one, and the range is bisected
// in ST_MID unless the key is above the upper entry or the limits adjoin.
// Every comparison waits on one read of the single-port table memory, and
// in_ready is low from a query's accept until its result is registered;
// the next beat is taken the cycle after.
// The result sits in an output register; while the receiver stalls it is
// held, a following query still runs but keeps in_ready low until the
// register drains, and loads are taken while no query is in flight.
// Reset clears the control state only; table contents are undefined until
// written, and no query may read an entry that was never loaded.
module sorted_table_interval_search #(
  parameter int TABLE_DEPTH = stis_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = stis_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_action,
  input  logic [stis_pkg::IDX_W-1:0]             in_entry_index,
  input  logic signed [stis_pkg::PORT_VAL_W-1:0] in_entry_value,
  input  logic signed [stis_pkg::PORT_VAL_W-1:0] in_search_key,
  input  logic [stis_pkg::IDX_W-1:0]             in_lower_index,
  input  logic [stis_pkg::IDX_W-1:0]             in_upper_index,
  input  logic                                   in_clamp_above,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [stis_pkg::IDX_W-1:0]             out_interval_index,
  output logic                                   out_found
);
  import stis_pkg::*;

  localparam int AddrW  = addr_width(TABLE_DEPTH);
  localparam int StoreW = store_width(VALUE_WIDTH);

  tbl_cmd_t          mem_cmd;
  logic [AddrW-1:0]  mem_addr;
  logic [StoreW-1:0] mem_wdata;
  logic [StoreW-1:0] mem_rdata;

  stis_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_entry_index     (in_entry_index),
    .in_entry_value     (in_entry_value),
    .in_search_key      (in_search_key),
    .in_lower_index     (in_lower_index),
    .in_upper_index     (in_upper_index),
    .in_clamp_above     (in_clamp_above),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_interval_index (out_interval_index),
    .out_found          (out_found),
    .mem_cmd            (mem_cmd),
    .mem_addr           (mem_addr),
    .mem_wdata          (mem_wdata),
    .mem_rdata          (mem_rdata)
  );

  stis_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_table (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

/* verif/sorted_table_interval_search_tb.sv */
module sorted_table_interval_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stis_pkg::*;

  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;
  localparam int PHASE_BEATS = 155;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic                         action;
    logic [IDX_W-1:0]             entry_index;
    logic signed [PORT_VAL_W-1:0] entry_value;
    logic signed [PORT_VAL_W-1:0] search_key;
    logic [IDX_W-1:0]             lower_index;
    logic [IDX_W-1:0]             upper_index;
    logic                         clamp_above;
  } lookup_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] interval_index;
    logic             found;
  } interval_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_action = ACT_LOAD;
  logic [IDX_W-1:0]             in_entry_index = '0;
  logic signed [PORT_VAL_W-1:0] in_entry_value = '0;
  logic signed [PORT_VAL_W-1:0] in_search_key = '0;
  logic [IDX_W-1:0]             in_lower_index = '0;
  logic [IDX_W-1:0]             in_upper_index = '0;
  logic                         in_clamp_above = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [IDX_W-1:0]             out_interval_index;
  logic                         out_found;

  lookup_beat_t                 beat_queue[$];
  interval_t                    expected_intervals[$];
  logic signed [PORT_VAL_W-1:0] lookup_shadow[IDX_LIMIT];
  longint                       gen_value[IDX_LIMIT];
  int                           region_lo;
  int                           region_hi;
  int                           send_idle_pct = 0;
  int                           recv_stall_pct = 0;
  int                           errors = 0;
  int                           loads_accepted = 0;
  int                           queries_accepted = 0;
  int                           results_found = 0;
  int                           results_missed = 0;

  sorted_table_interval_search u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .in_search_key     (in_search_key),
    .in_lower_index    (in_lower_index),
    .in_upper_index    (in_upper_index),
    .in_clamp_above    (in_clamp_above),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_interval_index(out_interval_index),
    .out_found         (out_found)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // expected result of one accepted beat, table shadow updated on loads
  function automatic void interval_lookup(input lookup_beat_t b);
    logic signed [PORT_VAL_W-1:0] key;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic [IDX_W-1:0] mid;
    logic [IDX_W:0]   sum;
    interval_t r;
    if (b.action == ACT_LOAD) begin
      lookup_shadow[b.entry_index] = b.entry_value;
      return;
    end
    key = b.search_key;
    lo = b.lower_index;
    hi = b.upper_index;
    r = '0;
    if (hi > lo && !(key < lookup_shadow[lo])) begin
      if (key > lookup_shadow[hi]) begin
        if (b.clamp_above) begin
          r.interval_index = hi;
          r.found = 1'b1;
        end
      end else begin
        left = lo;
        right = hi;
        while (right - left > IDX_W'(1)) begin
          sum = {1'b0, left} + {1'b0, right};
          mid = sum[IDX_W:1];
          if (key > lookup_shadow[mid]) left = mid;
          else right = mid;
        end
        r.interval_index = left;
        r.found = 1'b1;
      end
    end
    expected_intervals.push_back(r);
  endfunction

  function automatic logic signed [PORT_VAL_W-1:0] clip_value(input longint v);
    if (v > VAL_MAX) return VAL_MAX[PORT_VAL_W-1:0];
    if (v < VAL_MIN) return VAL_MIN[PORT_VAL_W-1:0];
    return v[PORT_VAL_W-1:0];
  endfunction

  function automatic lookup_beat_t random_beat();
    lookup_beat_t b;
    b.action = 1'($urandom_range(1));
    b.entry_index = IDX_W'($urandom_range(IDX_LIMIT - 1));
    b.entry_value = $urandom();
    b.search_key = $urandom();
    b.lower_index = IDX_W'($urandom_range(IDX_LIMIT - 1));
    b.upper_index = IDX_W'($urandom_range(IDX_LIMIT - 1));
    b.clamp_above = 1'($urandom_range(1));
    return b;
  endfunction

  task automatic queue_beat(input lookup_beat_t b);
    if (b.action == ACT_LOAD) gen_value[b.entry_index] = longint'(b.entry_value);
    beat_queue.push_back(b);
  endtask

  task automatic queue_load(input int idx, input longint v);
    lookup_beat_t b;
    b = random_beat();
    b.action = ACT_LOAD;
    b.entry_index = idx[IDX_W-1:0];
    b.entry_value = clip_value(v);
    queue_beat(b);
  endtask

  task automatic queue_query(input longint key, input int lo, input int hi,
                             input logic clamp);
    lookup_beat_t b;
    b = random_beat();
    b.action = ACT_QUERY;
    b.search_key = clip_value(key);
    b.lower_index = lo[IDX_W-1:0];
    b.upper_index = hi[IDX_W-1:0];
    b.clamp_above = clamp;
    queue_beat(b);
  endtask

  // non-decreasing run of loads from base, returns number of beats queued
  task automatic queue_sorted_run(input int base, input int len, input longint start,
                                  input int max_step, output int n);
    longint v;
    v = start;
    n = 0;
    for (int i = 0; i < len && base + i < IDX_LIMIT; i++) begin
      queue_load(base + i, v);
      v = longint'(clip_value(v + longint'($urandom_range(max_step))));
      n++;
    end
    region_lo = base;
    region_hi = base + n - 1;
  endtask

  task automatic queue_phase(input int n_beats);
    int count;
    int r;
    int s;
    int lo;
    int hi;
    int n;
    int max_step;
    longint key;
    longint span;
    lookup_beat_t b;
    count = 0;
    while (count < n_beats) begin
      r = $urandom_range(99);
      if (r < 8) begin
        case ($urandom_range(3))
          0: max_step = 0;
          1: max_step = 3;
          2: max_step = 65536;
          default: max_step = 50000000;
        endcase
        queue_sorted_run($urandom_range(IDX_LIMIT - 1), $urandom_range(2, 24),
                         longint'($signed($urandom())), max_step, n);
        count += n;
      end else if (r < 16) begin
        b = random_beat();
        b.action = ACT_LOAD;
        queue_beat(b);
        count++;
      end else if (r < 28) begin
        b = random_beat();
        b.action = ACT_QUERY;
        queue_beat(b);
        count++;
      end else begin
        s = $urandom_range(99);
        if (s < 5) begin
          lo = 0;
          hi = IDX_LIMIT - 1;
        end else if (s < 60 && region_hi > region_lo) begin
          lo = $urandom_range(region_lo, region_hi - 1);
          hi = $urandom_range(lo + 1, region_hi);
        end else begin
          lo = $urandom_range(IDX_LIMIT - 2);
          hi = lo + $urandom_range(1, 64);
          if (hi > IDX_LIMIT - 1) hi = IDX_LIMIT - 1;
        end
        s = $urandom_range(99);
        if (s < 35) begin
          key = gen_value[IDX_W'($urandom_range(lo, hi))]
              + longint'($urandom_range(2)) - 1;
        end else if (s < 55) key = gen_value[lo[IDX_W-1:0]] - longint'($urandom_range(1, 3));
        else if (s < 75) key = gen_value[hi[IDX_W-1:0]] + longint'($urandom_range(1, 3));
        else if (s < 90) begin
          span = gen_value[hi[IDX_W-1:0]] - gen_value[lo[IDX_W-1:0]];
          key = gen_value[lo[IDX_W-1:0]];
          if (span > 0) key += longint'($urandom()) % span;
        end else key = $urandom_range(1) ? VAL_MAX : VAL_MIN;
        queue_query(key, lo, hi, 1'($urandom_range(1)));
        count++;
      end
    end
  endtask

  // sender holds off until every result has come back
  task automatic drain();
    while (beat_queue.size() != 0 || in_valid || expected_intervals.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_beats
    lookup_beat_t nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        interval_lookup({in_action, in_entry_index, in_entry_value, in_search_key,
                         in_lower_index, in_upper_index, in_clamp_above});
        if (in_action == ACT_LOAD) loads_accepted++;
        else queries_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (beat_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nb = beat_queue.pop_front();
          in_action      <= nb.action;
          in_entry_index <= nb.entry_index;
          in_entry_value <= nb.entry_value;
          in_search_key  <= nb.search_key;
          in_lower_index <= nb.lower_index;
          in_upper_index <= nb.upper_index;
          in_clamp_above <= nb.clamp_above;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    interval_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_intervals.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none actual index %0d found %0b",
                   $time, out_interval_index, out_found);
        end else begin
          exp_r = expected_intervals.pop_front();
          if (out_found) results_found++;
          else results_missed++;
          if (out_found !== exp_r.found) begin
            errors++;
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, exp_r.found, out_found);
          end
          if (out_interval_index !== exp_r.interval_index) begin
            errors++;
            $display("%0t: interval_index mismatch, expected %0d actual %0d",
                     $time, exp_r.interval_index, out_interval_index);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int n;
    region_lo = 0;
    region_hi = 5;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, duplicates, key on the lower and upper entry
    queue_load(0, VAL_MIN);
    queue_load(1, -65536);
    queue_load(2, 0);
    queue_load(3, 0);
    queue_load(4, 65536);
    queue_load(5, VAL_MAX);
    queue_load(IDX_LIMIT - 1, VAL_MAX);
    queue_query(VAL_MIN, 0, 5, 1'b0);
    queue_query(VAL_MAX, 0, 5, 1'b1);
    queue_query(0, 0, 5, 1'b0);
    queue_query(100, 1, 4, 1'b0);
    queue_query(-70000, 1, 4, 1'b1);
    queue_query(5, 0, 3, 1'b1);
    queue_query(5, 0, 3, 1'b0);
    queue_query(0, 2, 3, 1'b1);
    queue_query(0, 5, 2, 1'b1);
    queue_query(0, 3, 3, 1'b1);
    queue_query(VAL_MAX, IDX_LIMIT - 1, 0, 1'b1);
    queue_query(VAL_MIN, 0, 0, 1'b1);
    queue_query(-65536, 1, 2, 1'b0);
    queue_query(65535, 2, 4, 1'b0);
    drain();

    // whole table written in non-decreasing order, so every later query is legal
    @(negedge clk);
    queue_sorted_run(0, IDX_LIMIT, VAL_MIN + longint'($urandom_range(100000000)),
                     4000000, n);
    queue_phase(PHASE_BEATS);
    drain();

    @(negedge clk);
    send_idle_pct = 69;
    recv_stall_pct = 0;
    queue_phase(PHASE_BEATS);
    drain();

    @(negedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    queue_phase(PHASE_BEATS);
    drain();

    @(negedge clk);
    send_idle_pct = 20;
    recv_stall_pct = 20;
    queue_phase(PHASE_BEATS);
    drain();

    if (expected_intervals.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_intervals.size());
    end
    $display("Covered %0d table loads and %0d queries (%0d found, %0d not found)",
             loads_accepted, queries_accepted, results_found, results_missed);
    $display("over free-running, sender-idle, receiver-stall and mixed phases");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("%0t: timeout", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sorted_table_interval_search.f */
rtl/stis_pkg.sv
rtl/stis_table.sv
rtl/stis_ctrl.sv
rtl/sorted_table_interval_search.sv
verif/sorted_table_interval_search_tb.sv
